/* hdl/bdv_pkg.sv */
// ----------------------------------------------------------------------------
// bdv_pkg
// Shared types, constants and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bdv_pkg;

   // default number of entries in the queue between front and back
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CHAR = 2'd1,
      STATUS_MIXED    = 2'd2,
      STATUS_BAD_PAD  = 2'd3
   } status_type;

   // alphabet class of one character
   typedef enum logic [2:0] {
      CLS_COMMON = 3'd0,   // letter or digit, common to all alphabets
      CLS_PLUS   = 3'd1,   // '+'
      CLS_SLASH  = 3'd2,   // '/'
      CLS_COMMA  = 3'd3,   // ','
      CLS_URL    = 3'd4    // '-' or '_'
   } char_class_type;

   // variant flags
   localparam logic [3:0] VF_URL   = 4'h1;
   localparam logic [3:0] VF_BOTH  = 4'h2;
   localparam logic [3:0] VF_STAND = 4'h4;
   localparam logic [3:0] VF_IMAP  = 4'h8;

   // ASCII codes
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;

   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;

   // one classified character as it travels from front to back
   typedef struct packed {
      logic [5:0]     sextet;
      char_class_type cls;
      logic           is_pad;
      logic           is_bad;
      logic           last;
   } char_item_type;

   function automatic char_item_type classify(input logic [7:0] c, input logic last);
      char_item_type item;
      item.sextet = '0;
      item.cls    = CLS_COMMON;
      item.is_pad = 1'b0;
      item.is_bad = 1'b0;
      item.last   = last;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         item.sextet = 6'(c - CH_UPPER_A);
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         item.sextet = 6'(c - CH_LOWER_A + LOWER_BASE);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         item.sextet = 6'(c - CH_ZERO + DIGIT_BASE);
      end else if (c == CH_PLUS) begin
         item.sextet = 6'd62;
         item.cls    = CLS_PLUS;
      end else if (c == CH_SLASH) begin
         item.sextet = 6'd63;
         item.cls    = CLS_SLASH;
      end else if (c == CH_COMMA) begin
         item.sextet = 6'd63;
         item.cls    = CLS_COMMA;
      end else if (c == CH_MINUS) begin
         item.sextet = 6'd62;
         item.cls    = CLS_URL;
      end else if (c == CH_UNDER) begin
         item.sextet = 6'd63;
         item.cls    = CLS_URL;
      end else if (c == CH_EQUAL) begin
         item.is_pad = 1'b1;
      end else begin
         item.is_bad = 1'b1;
      end
      return item;
   endfunction

endpackage

`default_nettype wire

/* hdl/bdv_front.sv */
// ----------------------------------------------------------------------------
// bdv_front
// Accepts characters and classifies them into sextet and alphabet class.
// ----------------------------------------------------------------------------
`default_nettype none

module bdv_front
   import bdv_pkg::*;
(
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,    // [7:0] char_in
   input  wire logic          req_tlast,
   output logic               push_valid,
   output char_item_type      push_item,
   input  wire logic          push_ready
);

   // accept whenever the queue has room
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign push_item  = classify(req_tdata, req_tlast);

endmodule

`default_nettype wire

/* hdl/bdv_queue.sv */
// ----------------------------------------------------------------------------
// bdv_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdv_queue
   import bdv_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
)(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire char_item_type push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output char_item_type      pop_item,
   input  wire logic          pop_ready
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   char_item_type   entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            push, pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/bdv_back.sv */
// ----------------------------------------------------------------------------
// bdv_back
// Runs the group and variant state per character and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bdv_back
   import bdv_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          pad_required,
   input  wire logic          pop_valid,
   input  wire char_item_type pop_item,
   output logic               pop_ready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [15:0]        rsp_tdata,    // [7:0] data_byte, [9:8] status, rest zero
   output logic               rsp_tlast,    // done_res
   output logic               rsp_tuser     // byte_valid
);

   logic [5:0] held_ff, held_in;
   logic [1:0] pos_ff, pos_in;
   logic [3:0] vf_ff, vf_in;
   logic       pad_seen_ff, pad_seen_in;
   status_type err_ff, err_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_bvalid_ff, out_bvalid_in;
   logic       out_done_ff, out_done_in;
   status_type out_status_ff, out_status_in;

   logic       take;
   logic       byte_ok;
   logic [7:0] byte_val;
   status_type err_next;

   // pop while the result register is empty or drains this cycle
   assign pop_ready = !out_valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      held_in       = held_ff;
      pos_in        = pos_ff;
      vf_in         = vf_ff;
      pad_seen_in   = pad_seen_ff;
      err_next      = err_ff;
      byte_ok       = 1'b0;
      byte_val      = '0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_done_in   = out_done_ff;
      out_status_in = out_status_ff;

      if (err_ff == STATUS_OK) begin
         if (pad_seen_ff) begin
            if (!(pop_item.is_pad && pos_ff == 2'd3)) begin
               err_next = STATUS_BAD_PAD;
            end
         end else if (pop_item.is_pad) begin
            if (pos_ff >= 2'd2) begin
               pad_seen_in = 1'b1;
            end else begin
               err_next = STATUS_BAD_PAD;
            end
         end else if (pop_item.is_bad) begin
            err_next = STATUS_BAD_CHAR;
         end else begin
            unique case (pop_item.cls)
               CLS_PLUS: begin
                  if ((vf_ff & VF_URL) != '0) err_next = STATUS_MIXED;
                  else vf_in = vf_ff | VF_BOTH;
               end
               CLS_SLASH: begin
                  if ((vf_ff & (VF_URL | VF_IMAP)) != '0) err_next = STATUS_MIXED;
                  else vf_in = VF_BOTH | VF_STAND;
               end
               CLS_COMMA: begin
                  if ((vf_ff & (VF_URL | VF_STAND)) != '0) err_next = STATUS_MIXED;
                  else vf_in = VF_BOTH | VF_IMAP;
               end
               CLS_URL: begin
                  if ((vf_ff & VF_BOTH) != '0) err_next = STATUS_MIXED;
                  else vf_in = VF_URL;
               end
               default: begin
               end
            endcase
            if (err_next == STATUS_OK) begin
               unique case (pos_ff)
                  2'd1: byte_val = {held_ff, pop_item.sextet[5:4]};
                  2'd2: byte_val = {held_ff[3:0], pop_item.sextet[5:2]};
                  2'd3: byte_val = {held_ff[1:0], pop_item.sextet};
                  default: byte_val = '0;
               endcase
               byte_ok = (pos_ff != 2'd0);
               held_in = pop_item.sextet;
            end
         end
      end
      pos_in = pos_ff + 2'd1;

      // length check on the final character
      if (pop_item.last && err_next == STATUS_OK) begin
         if (pos_ff == 2'd0 || (pad_required && pos_ff != 2'd3)) begin
            err_next = STATUS_BAD_PAD;
         end
      end
      err_in = err_next;

      if (take) begin
         if (byte_ok || pop_item.last) begin
            out_valid_in  = 1'b1;
            out_byte_in   = byte_val;
            out_bvalid_in = byte_ok;
            out_done_in   = pop_item.last;
            out_status_in = pop_item.last ? err_next : STATUS_OK;
         end
         // drop all string state after the final character
         if (pop_item.last) begin
            held_in     = '0;
            pos_in      = '0;
            vf_in       = '0;
            pad_seen_in = 1'b0;
            err_in      = STATUS_OK;
         end
      end else begin
         held_in     = held_ff;
         pos_in      = pos_ff;
         vf_in       = vf_ff;
         pad_seen_in = pad_seen_ff;
         err_in      = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         pos_ff       <= '0;
         vf_ff        <= '0;
         pad_seen_ff  <= 1'b0;
         err_ff       <= STATUS_OK;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         pos_ff       <= pos_in;
         vf_ff        <= vf_in;
         pad_seen_ff  <= pad_seen_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_done_ff   <= out_done_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_status_ff, out_byte_ff};
   assign rsp_tlast  = out_done_ff;
   assign rsp_tuser  = out_bvalid_ff;

   // a result carries an octet, a final status or both
   a_result_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser || rsp_tlast))
      else $error("result without octet or status");

   // status stays zero on results that are not final
   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (out_status_ff == STATUS_OK))
      else $error("status on a non-final result");

   // the string state is clean after a final character is taken
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && pop_item.last) |=> (pos_ff == 2'd0 && vf_ff == 4'd0 &&
                                   !pad_seen_ff && err_ff == STATUS_OK))
      else $error("string state not cleared after last character");

   // once an error is set, no further octet is produced within the string
   a_no_byte_after_error: assert property (@(posedge clock) disable iff (reset)
      (take && err_ff != STATUS_OK) |=> !(out_valid_ff && out_bvalid_ff))
      else $error("octet produced after an error");

endmodule

`default_nettype wire

/* hdl/base64_decoder_variant_check.sv */
// ----------------------------------------------------------------------------
// base64_decoder_variant_check
// Streaming base64 decoder for the standard, URL-safe and IMAP alphabets
// that locks onto the first variant seen and reports a final status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | content
//  --------+-----------+------------------------+-------------------------------
//  req     | in        | req_tvalid/req_tready  | tdata[7:0] char_in, tlast last_char
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata[7:0] data_byte, [9:8] status,
//          |           |                        | tuser byte_valid, tlast done_res
//  csr     | in        | csr_valid/csr_ready    | csr_data pad_required
//
//  One character per cycle sustained while rsp is not stalled; a character is
//  written to the queue at its accepting edge, and its result lands in the
//  result register when the back takes it from the queue, then is offered on rsp.
//  The back state loop (group position, held sextet, variant flags) sets the
//  rate. Reset is synchronous and clears queue, state and pad_required.
//  A stalled rsp side fills the queue, then drops req_tready; the queue lets
//  front and back stall on their own. Characters that complete no octet and are
//  not final give no result. csr_ready stays high; write only while idle.
//
// ----------------------------------------------------------------------------
`default_nettype none

module base64_decoder_variant_check
   import bdv_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth   // two or more entries
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_in
   input  wire logic        req_tlast,    // last_char
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [7:0] data_byte, [9:8] status, [15:10] zero
   output logic             rsp_tlast,    // done_res
   output logic             rsp_tuser,    // [0] byte_valid
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data      // pad_required
);

   char_item_type push_item, pop_item;
   logic          push_valid, push_ready;
   logic          pop_valid, pop_ready;
   logic          pad_required_ff, pad_required_in;

   // hold the configuration; the user must write only while idle, the block does not enforce it
   assign csr_ready       = 1'b1;
   assign pad_required_in = (csr_valid && csr_ready) ? csr_data : pad_required_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_required_ff <= 1'b0;
      end else begin
         pad_required_ff <= pad_required_in;
      end
   end

   // front: accept and classify each transaction
   bdv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // queue: decouple classification from decoding
   bdv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // back: advance the group state and register each result
   bdv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pad_required (pad_required_ff),
      .pop_valid    (pop_valid),
      .pop_item     (pop_item),
      .pop_ready    (pop_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

`default_nettype wire
